// ----- sv/nwt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and widths for the night window trigger.
// No dependencies; compiled first.
package nwt_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 11;

    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_NIGHT   = 2'd1;
    localparam logic [1:0] FUNC_LOCK    = 2'd2;
    localparam logic [1:0] FUNC_STOPPED = 2'd3;

    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_TIME   = 3'd1;
    localparam logic [2:0] MODE_SUN    = 3'd2;
    localparam logic [2:0] MODE_EITHER = 3'd3;
    localparam logic [2:0] MODE_BOTH   = 3'd4;

    localparam logic [1:0] REL_BEFORE = 2'd0;
    localparam logic [1:0] REL_AT     = 2'd1;
    localparam logic [1:0] REL_AFTER  = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_START_MODE       = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_END_MODE         = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SUNSET_RELATION  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SUNSET_OFFSET    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SUNRISE_RELATION = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_SUNRISE_OFFSET   = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_START_MINUTE     = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_STOP_MINUTE      = 3'd7;

    localparam logic [4:0] NOON_HOUR = 5'd12;

    typedef struct packed {
        logic [2:0]  start_mode;
        logic [2:0]  end_mode;
        logic [1:0]  sunset_relation;
        logic [9:0]  sunset_offset;
        logic [1:0]  sunrise_relation;
        logic [9:0]  sunrise_offset;
        logic [10:0] start_minute;
        logic [10:0] stop_minute;
    } t_cfg;

    typedef struct packed {
        logic time_seen;
        logic sun_seen;
    } t_seen;

endpackage

// ----- sv/nwt_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels for tick/command items and result items.
// Standalone; compiled after nwt_pkg.
interface nwt_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [4:0]        day_number;
    logic              evaluate;
    logic [10:0]       minute_of_day;
    logic [4:0]        hour;
    logic signed [10:0] elevation;
    logic              switch_value;

    modport source (output valid, func, day_number, evaluate, minute_of_day, hour,
                    elevation, switch_value, input ready);
    modport sink (input valid, func, day_number, evaluate, minute_of_day, hour,
                  elevation, switch_value, output ready);
endinterface

interface nwt_out_if;
    logic valid;
    logic ready;
    logic night_allowed;
    logic lock_state;
    logic start_position_suppressed;

    modport source (output valid, night_allowed, lock_state, start_position_suppressed,
                    input ready);
    modport sink (input valid, night_allowed, lock_state, start_position_suppressed,
                  output ready);
endinterface

// ----- sv/nwt_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register file, written by index.
// Depends on nwt_pkg.
module nwt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nwt_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [nwt_pkg::CfgDataW-1:0]  i_cfg_data,
    output nwt_pkg::t_cfg                 o_cfg
);
    import nwt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_mode       <= MODE_NONE;
            r_cfg.end_mode         <= MODE_NONE;
            r_cfg.sunset_relation  <= REL_AT;
            r_cfg.sunset_offset    <= '0;
            r_cfg.sunrise_relation <= REL_AT;
            r_cfg.sunrise_offset   <= '0;
            r_cfg.start_minute     <= '0;
            r_cfg.stop_minute      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_MODE:       r_cfg.start_mode       <= i_cfg_data[2:0];
                CFG_END_MODE:         r_cfg.end_mode         <= i_cfg_data[2:0];
                CFG_SUNSET_RELATION:  r_cfg.sunset_relation  <= i_cfg_data[1:0];
                CFG_SUNSET_OFFSET:    r_cfg.sunset_offset    <= i_cfg_data[9:0];
                CFG_SUNRISE_RELATION: r_cfg.sunrise_relation <= i_cfg_data[1:0];
                CFG_SUNRISE_OFFSET:   r_cfg.sunrise_offset   <= i_cfg_data[9:0];
                CFG_START_MINUTE:     r_cfg.start_minute     <= i_cfg_data;
                CFG_STOP_MINUTE:      r_cfg.stop_minute      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/nwt_rule.sv -----
`timescale 1ns / 1ps
// One start or end rule: time match, sun event, either first or both.
// Depends on nwt_pkg.
module nwt_rule (
    input  logic [2:0]     i_mode,
    input  logic           i_time_hit,
    input  logic           i_sun_ok,
    input  nwt_pkg::t_seen i_seen,
    output nwt_pkg::t_seen o_seen,
    output logic           o_trig
);
    import nwt_pkg::*;

    logic do_time;
    logic do_sun;
    logic is_both;
    logic time_ev;
    logic sun_ev;
    logic time_trig;

    always_comb begin
        do_time = (i_mode == MODE_TIME) || (i_mode == MODE_EITHER) || (i_mode == MODE_BOTH);
        do_sun  = (i_mode == MODE_SUN) || (i_mode == MODE_EITHER) || (i_mode == MODE_BOTH);
        is_both = (i_mode == MODE_BOTH);
        time_ev = do_time && !i_seen.time_seen && i_time_hit;
        sun_ev  = do_sun && !i_seen.sun_seen && i_sun_ok;
        o_seen.time_seen = i_seen.time_seen || time_ev;
        o_seen.sun_seen  = i_seen.sun_seen || sun_ev;
        time_trig = time_ev && (!is_both || i_seen.sun_seen);
        // a sun event overrides the time decision of the same pass
        if (sun_ev) begin
            o_trig = !is_both || o_seen.time_seen;
        end else begin
            o_trig = time_trig;
        end
    end

endmodule

// ----- sv/night_window_trigger_top.sv -----
`timescale 1ns / 1ps
// Night window trigger: state update and registered result per item.
// Latency: the result item is valid the cycle after its input item is accepted.
// Throughput: one item per cycle; input stays ready while the result register
// is empty or being drained in the same cycle.
// Reset: synchronous, clears all flags, the day and the configuration to defaults.
// Depends on nwt_pkg, nwt_if, nwt_cfg, nwt_rule.
module night_window_trigger_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nwt_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [nwt_pkg::CfgDataW-1:0]  i_cfg_data,
    nwt_in_if.sink                        i_in,
    nwt_out_if.source                     o_out
);
    import nwt_pkg::*;

    t_cfg  cfg;
    logic [4:0] r_last_day;
    t_seen r_start_seen, r_end_seen;
    logic  r_night, r_lock, r_supp;
    logic  r_out_valid;
    logic  r_out_night, r_out_lock, r_out_supp;

    logic [4:0] n_last_day;
    t_seen n_start_seen, n_end_seen;
    logic  n_night, n_lock, n_supp;

    logic  accept;
    logic  is_tick;
    logic  day_chg;
    t_seen base_start, base_end;
    t_seen rule_start_seen, rule_end_seen;
    logic  start_trig, end_trig;
    logic signed [11:0] elev_ext, set_thr, rise_thr;
    logic  set_ok, rise_ok;

    nwt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        elev_ext = {i_in.elevation[10], i_in.elevation};
        case (cfg.sunset_relation)
            REL_BEFORE: set_thr = $signed({2'b00, cfg.sunset_offset});
            REL_AFTER:  set_thr = -$signed({2'b00, cfg.sunset_offset});
            default:    set_thr = '0;
        endcase
        case (cfg.sunrise_relation)
            REL_BEFORE: rise_thr = -$signed({2'b00, cfg.sunrise_offset});
            REL_AFTER:  rise_thr = $signed({2'b00, cfg.sunrise_offset});
            default:    rise_thr = '0;
        endcase
        set_ok  = (i_in.hour > NOON_HOUR) && (elev_ext <= set_thr);
        rise_ok = (i_in.hour < NOON_HOUR) && (elev_ext >= rise_thr);
        is_tick = (i_in.func == FUNC_TICK);
        day_chg = (i_in.day_number != r_last_day);
        base_start = (is_tick && day_chg) ? '0 : r_start_seen;
        base_end   = (is_tick && day_chg) ? '0 : r_end_seen;
    end

    nwt_rule u_start_rule (
        .i_mode     (cfg.start_mode),
        .i_time_hit (i_in.minute_of_day == cfg.start_minute),
        .i_sun_ok   (set_ok),
        .i_seen     (base_start),
        .o_seen     (rule_start_seen),
        .o_trig     (start_trig)
    );

    nwt_rule u_end_rule (
        .i_mode     (cfg.end_mode),
        .i_time_hit (i_in.minute_of_day == cfg.stop_minute),
        .i_sun_ok   (rise_ok),
        .i_seen     (base_end),
        .o_seen     (rule_end_seen),
        .o_trig     (end_trig)
    );

    always_comb begin
        n_last_day   = r_last_day;
        n_start_seen = r_start_seen;
        n_end_seen   = r_end_seen;
        n_night      = r_night;
        n_lock       = r_lock;
        n_supp       = r_supp;
        case (i_in.func)
            FUNC_TICK: begin
                n_last_day = i_in.day_number;
                if (i_in.evaluate) begin
                    n_start_seen = rule_start_seen;
                    n_end_seen   = rule_end_seen;
                    if (start_trig) begin
                        n_night = 1'b1;
                    end
                    if (end_trig) begin
                        n_night = 1'b0;
                        n_supp  = 1'b0;
                    end
                end else begin
                    n_start_seen = base_start;
                    n_end_seen   = base_end;
                end
            end
            FUNC_NIGHT: begin
                n_night = i_in.switch_value;
                if (i_in.switch_value) begin
                    n_supp = 1'b0;
                end
            end
            FUNC_LOCK: begin
                n_lock = i_in.switch_value;
            end
            default: begin
                if (r_night) begin
                    n_supp = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_day   <= '0;
            r_start_seen <= '0;
            r_end_seen   <= '0;
            r_night      <= 1'b0;
            r_lock       <= 1'b0;
            r_supp       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_last_day   <= n_last_day;
                r_start_seen <= n_start_seen;
                r_end_seen   <= n_end_seen;
                r_night      <= n_night;
                r_lock       <= n_lock;
                r_supp       <= n_supp;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_night <= n_night && !n_lock;
            r_out_lock  <= n_lock;
            r_out_supp  <= n_supp;
        end
    end

    assign o_out.valid                     = r_out_valid;
    assign o_out.night_allowed             = r_out_night;
    assign o_out.lock_state                = r_out_lock;
    assign o_out.start_position_suppressed = r_out_supp;

`ifndef NO_ASSERTIONS
    a_out_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_lock == r_lock) && (r_out_supp == r_supp)
                        && (r_out_night == (r_night && !r_lock)))
        else $error("result register does not match flag state");

    a_lock_blocks_night: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_lock) |-> !r_out_night)
        else $error("night allowed while locked");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result stalled");

    a_day_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_tick) |=> (r_last_day == $past(i_in.day_number)))
        else $error("day number not captured on tick");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for night_window_trigger_top: a directed table, then random day runs.
// Uses nwt_pkg and the nwt_in_if / nwt_out_if channels from the RTL.
module tb;
    import nwt_pkg::*;

    localparam int QuietLimit = 2000;
    localparam int PressureHold = 150;
    localparam int SettleCycles = 3;
    localparam int RandPhases = 14;
    localparam int ItemsPerPhase = 100;

    typedef struct packed {
        logic [1:0]         func;
        logic [4:0]         day_number;
        logic               evaluate;
        logic [10:0]        minute_of_day;
        logic [4:0]         hour;
        logic signed [10:0] elevation;
        logic               switch_value;
    } t_item;

    typedef struct packed {
        logic night_allowed;
        logic lock_state;
        logic suppressed;
    } t_verdict;

    typedef struct packed {
        logic [4:0] last_day;
        t_seen      start_seen;
        t_seen      end_seen;
        logic       night;
        logic       lock;
        logic       suppress;
    } t_window;

    typedef struct packed {
        logic  trig;
        t_seen seen;
    } t_rule_res;

    typedef struct {
        int       phase;
        t_item    item;
        bit       fixed;
        t_verdict want;
    } t_row;

    localparam int ItemW = $bits(t_item);
    localparam int CfgW = $bits(t_cfg);

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    nwt_in_if  in_if ();
    nwt_out_if out_if ();

    night_window_trigger_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    t_cfg     cfg_shadow;
    t_window  win;
    t_verdict verdict_q[$];
    bit       pin_fixed = 1'b0;
    t_verdict pin_want = '0;
    int       n_in = 0;
    int       n_out = 0;
    int       n_cfg = 0;
    int       n_bad = 0;
    int       quiet = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_rule_res run_trigger(logic [2:0] mode, logic time_hit, logic sun_ok,
                                              t_seen seen);
        t_rule_res res;
        logic      by_time;
        logic      by_sun;
        by_time = (mode == MODE_TIME) || (mode == MODE_EITHER) || (mode == MODE_BOTH);
        by_sun = (mode == MODE_SUN) || (mode == MODE_EITHER) || (mode == MODE_BOTH);
        res.trig = 1'b0;
        res.seen = seen;
        if (by_time && !res.seen.time_seen && time_hit) begin
            res.seen.time_seen = 1'b1;
            res.trig = (mode == MODE_BOTH) ? res.seen.sun_seen : 1'b1;
        end
        if (by_sun && !res.seen.sun_seen && sun_ok) begin
            res.seen.sun_seen = 1'b1;
            res.trig = (mode == MODE_BOTH) ? res.seen.time_seen : 1'b1;
        end
        return res;
    endfunction

    function automatic t_verdict step_window(t_item it);
        t_rule_res r;
        t_verdict  v;
        int        elev;
        int        set_thr;
        int        rise_thr;
        logic      set_ok;
        logic      rise_ok;
        elev = int'(it.elevation);
        case (cfg_shadow.sunset_relation)
            REL_BEFORE: set_thr = int'(cfg_shadow.sunset_offset);
            REL_AFTER:  set_thr = -int'(cfg_shadow.sunset_offset);
            default:    set_thr = 0;
        endcase
        case (cfg_shadow.sunrise_relation)
            REL_BEFORE: rise_thr = -int'(cfg_shadow.sunrise_offset);
            REL_AFTER:  rise_thr = int'(cfg_shadow.sunrise_offset);
            default:    rise_thr = 0;
        endcase
        case (it.func)
            FUNC_TICK: begin
                if (it.day_number != win.last_day) begin
                    win.last_day = it.day_number;
                    win.start_seen = '0;
                    win.end_seen = '0;
                end
                if (it.evaluate) begin
                    set_ok = (it.hour > NOON_HOUR) && (elev <= set_thr);
                    rise_ok = (it.hour < NOON_HOUR) && (elev >= rise_thr);
                    r = run_trigger(cfg_shadow.start_mode,
                                    it.minute_of_day == cfg_shadow.start_minute,
                                    set_ok, win.start_seen);
                    win.start_seen = r.seen;
                    if (r.trig) win.night = 1'b1;
                    r = run_trigger(cfg_shadow.end_mode,
                                    it.minute_of_day == cfg_shadow.stop_minute,
                                    rise_ok, win.end_seen);
                    win.end_seen = r.seen;
                    if (r.trig) begin
                        win.night = 1'b0;
                        win.suppress = 1'b0;
                    end
                end
            end
            FUNC_NIGHT: begin
                win.night = it.switch_value;
                if (it.switch_value) win.suppress = 1'b0;
            end
            FUNC_LOCK: win.lock = it.switch_value;
            default: begin
                if (win.night) win.suppress = 1'b1;
            end
        endcase
        v.night_allowed = win.night && !win.lock;
        v.lock_state = win.lock;
        v.suppressed = win.suppress;
        return v;
    endfunction

    task automatic report_field(string what, logic want_v, logic got_v);
        if (want_v !== got_v) begin
            n_bad++;
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_verdict got;
        t_verdict want;
        t_item    taken;
        if (!i_rst_n) begin
            cfg_shadow = '0;
            cfg_shadow.sunset_relation = REL_AT;
            cfg_shadow.sunrise_relation = REL_AT;
            win = '0;
            quiet = 0;
        end else begin
            quiet++;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_MODE:       cfg_shadow.start_mode = i_cfg_data[2:0];
                    CFG_END_MODE:         cfg_shadow.end_mode = i_cfg_data[2:0];
                    CFG_SUNSET_RELATION:  cfg_shadow.sunset_relation = i_cfg_data[1:0];
                    CFG_SUNSET_OFFSET:    cfg_shadow.sunset_offset = i_cfg_data[9:0];
                    CFG_SUNRISE_RELATION: cfg_shadow.sunrise_relation = i_cfg_data[1:0];
                    CFG_SUNRISE_OFFSET:   cfg_shadow.sunrise_offset = i_cfg_data[9:0];
                    CFG_START_MINUTE:     cfg_shadow.start_minute = i_cfg_data;
                    default:              cfg_shadow.stop_minute = i_cfg_data;
                endcase
            end
            if (out_if.valid && out_if.ready) begin
                quiet = 0;
                n_out++;
                got.night_allowed = out_if.night_allowed;
                got.lock_state = out_if.lock_state;
                got.suppressed = out_if.start_position_suppressed;
                if (verdict_q.size() == 0) begin
                    n_bad++;
                    $display("%0t: result item with nothing expected, actual %b", $time, got);
                end else begin
                    want = verdict_q.pop_front();
                    report_field("night_allowed", want.night_allowed, got.night_allowed);
                    report_field("lock_state", want.lock_state, got.lock_state);
                    report_field("start_position_suppressed", want.suppressed,
                                 got.suppressed);
                end
            end
            if (in_if.valid && in_if.ready) begin
                quiet = 0;
                n_in++;
                taken.func = in_if.func;
                taken.day_number = in_if.day_number;
                taken.evaluate = in_if.evaluate;
                taken.minute_of_day = in_if.minute_of_day;
                taken.hour = in_if.hour;
                taken.elevation = in_if.elevation;
                taken.switch_value = in_if.switch_value;
                want = step_window(taken);
                verdict_q.push_back(pin_fixed ? pin_want : want);
            end
        end
    end

    initial begin : watchdog
        while (quiet < QuietLimit) @(posedge i_clk);
        $display("tb: done, errors");
        $finish;
    end

    function automatic int idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    initial begin : sink_side
        int run;
        int hold;
        out_if.ready = 1'b1;
        wait (i_rst_n === 1'b1 && n_in >= 40);
        @(posedge i_clk);
        out_if.ready <= 1'b0;
        repeat (PressureHold) @(posedge i_clk);
        forever begin
            out_if.ready <= 1'b1;
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
            repeat (run) @(posedge i_clk);
            hold = idle_len();
            out_if.ready <= 1'b0;
            repeat (hold) @(posedge i_clk);
        end
    end

    task automatic offer(t_item it, bit fixed, t_verdict want);
        in_if.valid <= 1'b1;
        in_if.func <= it.func;
        in_if.day_number <= it.day_number;
        in_if.evaluate <= it.evaluate;
        in_if.minute_of_day <= it.minute_of_day;
        in_if.hour <= it.hour;
        in_if.elevation <= it.elevation;
        in_if.switch_value <= it.switch_value;
        pin_fixed <= fixed;
        pin_want <= want;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
    endtask

    task automatic sender_pause();
        int n;
        if ($urandom_range(0, 2) != 0) return;
        n = idle_len();
        in_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_cfg(t_cfg c);
        put_reg(CFG_START_MODE, c.start_mode);
        put_reg(CFG_END_MODE, c.end_mode);
        put_reg(CFG_SUNSET_RELATION, c.sunset_relation);
        put_reg(CFG_SUNSET_OFFSET, c.sunset_offset);
        put_reg(CFG_SUNRISE_RELATION, c.sunrise_relation);
        put_reg(CFG_SUNRISE_OFFSET, c.sunrise_offset);
        put_reg(CFG_START_MINUTE, c.start_minute);
        put_reg(CFG_STOP_MINUTE, c.stop_minute);
        i_cfg_we <= 1'b0;
        n_cfg++;
    endtask

    function automatic t_cfg pick_cfg(int p);
        t_cfg c;
        c = t_cfg'(CfgW'({$urandom, $urandom}));
        case (p)
            0: c = '0;
            1: c = '1;
            2: c = '{start_mode: MODE_BOTH, end_mode: MODE_BOTH, sunset_relation: REL_AFTER,
                     sunset_offset: 10'd900, sunrise_relation: REL_AFTER,
                     sunrise_offset: 10'd900, start_minute: 11'd1439, stop_minute: 11'd1439};
            default: begin
                if ($urandom_range(0, 5) != 0) begin
                    c.start_mode = 3'($urandom_range(MODE_NONE, MODE_BOTH));
                    c.end_mode = 3'($urandom_range(MODE_NONE, MODE_BOTH));
                end
                if ($urandom_range(0, 5) != 0) begin
                    c.sunset_offset = 10'($urandom_range(0, 900));
                    c.sunrise_offset = 10'($urandom_range(0, 900));
                end
                if ($urandom_range(0, 5) != 0) begin
                    c.start_minute = 11'($urandom_range(0, 1439));
                    c.stop_minute = 11'($urandom_range(0, 1439));
                end
            end
        endcase
        return c;
    endfunction

    function automatic t_row row(int ph, logic [1:0] fn, int dy, bit ev, int mn, int hr,
                                 int el, bit sw, bit fixed, logic [2:0] want);
        t_row r;
        r.phase = ph;
        r.item.func = fn;
        r.item.day_number = 5'(dy);
        r.item.evaluate = ev;
        r.item.minute_of_day = 11'(mn);
        r.item.hour = 5'(hr);
        r.item.elevation = 11'(el);
        r.item.switch_value = sw;
        r.fixed = fixed;
        r.want = t_verdict'(want);
        return r;
    endfunction

    initial begin : stimulus
        t_row     rows[$];
        t_cfg     dir_cfg[3];
        t_cfg     cfg_now;
        t_item    it;
        int       cur_phase;
        int       minute;
        int       m;
        int       from_noon;
        int       sel;
        logic [4:0] day;
        bit       burst;

        in_if.valid = 1'b0;
        in_if.func = FUNC_TICK;
        in_if.day_number = '0;
        in_if.evaluate = 1'b0;
        in_if.minute_of_day = '0;
        in_if.hour = '0;
        in_if.elevation = '0;
        in_if.switch_value = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_cfg[0] = '0;
        dir_cfg[0].sunset_relation = REL_AT;
        dir_cfg[0].sunrise_relation = REL_AT;
        dir_cfg[1] = '{start_mode: MODE_BOTH, end_mode: MODE_BOTH, sunset_relation: REL_BEFORE,
                       sunset_offset: 10'd900, sunrise_relation: REL_AFTER,
                       sunrise_offset: 10'd900, start_minute: 11'd1200, stop_minute: 11'd360};
        dir_cfg[2] = '{start_mode: 3'd7, end_mode: MODE_EITHER, sunset_relation: 2'd3,
                       sunset_offset: 10'd900, sunrise_relation: 2'd3,
                       sunrise_offset: 10'd900, start_minute: 11'd100, stop_minute: 11'd1439};

        // rules off: only commands move the outputs
        rows.push_back(row(0, FUNC_TICK, 0, 1, 0, 0, 0, 0, 1, 3'b000));
        rows.push_back(row(0, FUNC_TICK, 31, 1, 2047, 31, -1024, 1, 1, 3'b000));
        rows.push_back(row(0, FUNC_TICK, 31, 1, 0, 0, 1023, 0, 1, 3'b000));
        rows.push_back(row(0, FUNC_NIGHT, 0, 0, 0, 0, 0, 1, 1, 3'b100));
        rows.push_back(row(0, FUNC_STOPPED, 0, 0, 0, 0, 0, 0, 1, 3'b101));
        rows.push_back(row(0, FUNC_LOCK, 0, 0, 0, 0, 0, 1, 1, 3'b011));
        rows.push_back(row(0, FUNC_LOCK, 0, 0, 0, 0, 0, 0, 1, 3'b101));
        rows.push_back(row(0, FUNC_NIGHT, 0, 0, 0, 0, 0, 0, 1, 3'b001));
        rows.push_back(row(0, FUNC_STOPPED, 0, 0, 0, 0, 0, 0, 1, 3'b001));
        rows.push_back(row(0, FUNC_NIGHT, 0, 0, 0, 0, 0, 1, 1, 3'b100));
        rows.push_back(row(0, FUNC_NIGHT, 0, 0, 0, 0, 0, 0, 1, 3'b000));
        // both-events mode, split and same-pass triggers
        rows.push_back(row(1, FUNC_TICK, 5, 0, 1200, 20, -100, 0, 0, 3'b000));
        rows.push_back(row(1, FUNC_TICK, 5, 1, 1200, 20, 950, 0, 0, 3'b000));
        rows.push_back(row(1, FUNC_TICK, 5, 1, 1201, 20, 900, 0, 0, 3'b000));
        rows.push_back(row(1, FUNC_STOPPED, 5, 0, 0, 0, 0, 0, 0, 3'b000));
        rows.push_back(row(1, FUNC_TICK, 5, 1, 360, 6, 900, 0, 0, 3'b000));
        rows.push_back(row(1, FUNC_TICK, 6, 1, 1200, 13, -1024, 0, 0, 3'b000));
        rows.push_back(row(1, FUNC_TICK, 6, 1, 360, 12, 1023, 0, 0, 3'b000));
        rows.push_back(row(1, FUNC_TICK, 6, 1, 361, 11, 899, 0, 0, 3'b000));
        rows.push_back(row(1, FUNC_TICK, 6, 1, 362, 11, 900, 0, 0, 3'b000));
        // unused start mode and unused relations
        rows.push_back(row(2, FUNC_NIGHT, 0, 0, 0, 0, 0, 1, 0, 3'b000));
        rows.push_back(row(2, FUNC_TICK, 6, 1, 100, 20, -1024, 0, 0, 3'b000));
        rows.push_back(row(2, FUNC_LOCK, 0, 0, 0, 0, 0, 1, 0, 3'b000));
        rows.push_back(row(2, FUNC_TICK, 6, 1, 500, 8, 0, 0, 0, 3'b000));
        rows.push_back(row(2, FUNC_LOCK, 0, 0, 0, 0, 0, 0, 0, 3'b000));

        cur_phase = -1;
        foreach (rows[k]) begin
            if (rows[k].phase != cur_phase) begin
                cur_phase = rows[k].phase;
                settle();
                load_cfg(dir_cfg[cur_phase]);
            end
            offer(rows[k].item, rows[k].fixed, rows[k].want);
            sender_pause();
        end

        for (int p = 0; p < RandPhases; p++) begin
            settle();
            cfg_now = pick_cfg(p);
            load_cfg(cfg_now);
            burst = ($urandom_range(0, 3) == 0);
            day = 5'($urandom_range(0, 31));
            minute = $urandom_range(0, 1439);
            for (int k = 0; k < ItemsPerPhase; k++) begin
                sel = $urandom_range(0, 99);
                it = t_item'(ItemW'({$urandom, $urandom}));
                if (sel < 10) begin
                    it.func = 2'($urandom_range(FUNC_NIGHT, FUNC_STOPPED));
                end else if (sel >= 16) begin
                    // advance a plausible day: minutes forward, sun following the clock
                    minute += $urandom_range(1, 45);
                    if (minute >= 1440) begin
                        minute -= 1440;
                        day++;
                    end
                    case ($urandom_range(0, 9))
                        0:       m = int'(cfg_now.start_minute);
                        1:       m = int'(cfg_now.stop_minute);
                        default: m = minute;
                    endcase
                    from_noon = (m > 720) ? m - 720 : 720 - m;
                    it.func = FUNC_TICK;
                    it.day_number = ($urandom_range(0, 19) == 0) ? 5'($urandom) : day;
                    it.evaluate = ($urandom_range(0, 9) != 0);
                    it.minute_of_day = 11'(m);
                    it.hour = 5'(m / 60);
                    it.elevation = 11'(600 - (from_noon * 5) / 3 + $urandom_range(0, 80) - 40);
                end
                offer(it, 1'b0, '0);
                if (!burst) sender_pause();
            end
        end

        settle();
        $display("summary: %0d items in, %0d results checked over %0d register loads",
                 n_in, n_out, n_cfg);
        $display("summary: commands, day changes, all rule modes incl. unused, %0d mismatches",
                 n_bad);
        if (n_bad == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
